>>> src/bmvw_pkg.sv
// Shared constants, types and the falloff table of the brush mesh vertex warp.
`timescale 1ns / 1ps
`default_nettype none
package bmvw_pkg;

   localparam int COS_TABLE_BITS = 8;
   localparam int COS_ENTRIES    = (1 << COS_TABLE_BITS) + 1;
   localparam int K_W            = COS_TABLE_BITS + 1;

   // square root: radicand holds r^2 scaled by 2^(2B); root is sqrt(r^2)*2^B
   localparam int ROOT_W  = (COS_TABLE_BITS + 15 > 16) ? COS_TABLE_BITS + 15 : 16;
   localparam int RAD_W   = 2 * ROOT_W;
   localparam int ISQ_LAT = ROOT_W;

   // divider by the 15-bit radius; quotient covers the table index and Q15 ratios
   localparam int QUO_W   = (K_W > 16) ? K_W : 16;
   localparam int DVD_W   = QUO_W + 15;
   localparam int DIV_LAT = QUO_W;

   // pipeline stage numbers (register index, first stage is 1)
   localparam int S_R2  = 3;
   localparam int S_S   = S_R2 + ISQ_LAT + DIV_LAT + 1;
   localparam int S_F   = S_S + 1;
   localparam int LAT   = S_F + 4;
   localparam int W4_DLY = ISQ_LAT + 1;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   typedef logic [2:0] mode_type;
   localparam mode_type MODE_FORWARD  = 3'd0;
   localparam mode_type MODE_MAGNIFY  = 3'd1;
   localparam mode_type MODE_ELLIPSE  = 3'd2;
   localparam mode_type MODE_HEIGHT   = 3'd3;
   localparam mode_type MODE_VERTICAL = 3'd4;

   typedef logic [2:0] csr_idx_type;
   localparam csr_idx_type CSR_WARP_MODE    = 3'd0;
   localparam csr_idx_type CSR_CENTER_X     = 3'd1;
   localparam csr_idx_type CSR_CENTER_Y     = 3'd2;
   localparam csr_idx_type CSR_BRUSH_RADIUS = 3'd3;
   localparam csr_idx_type CSR_STRENGTH_X   = 3'd4;
   localparam csr_idx_type CSR_STRENGTH_Y   = 3'd5;
   localparam csr_idx_type CSR_TARGET_X     = 3'd6;
   localparam csr_idx_type CSR_TARGET_Y     = 3'd7;

   typedef struct packed {
      logic               vld;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic signed [16:0] dx;
      logic signed [16:0] dy;
      logic               last;
      logic               in_brush;
   } side_type;

   // one axis of the final displacement: v + round(p*f*d / 2^29)
   typedef struct packed {
      logic               chg;
      logic signed [15:0] p;
      logic [15:0]        f;
      logic signed [16:0] d;
      logic signed [15:0] v;
   } apply_op_type;

   typedef logic [COS_ENTRIES-1:0][15:0] cos_tab_type;

   function automatic logic [15:0] mul_q15(input logic [15:0] a, input logic [15:0] b);
      logic [31:0] pr;
      pr = 32'(a) * 32'(b) + 32'd16384;
      return pr[30:15];
   endfunction

   // cos(a)^2 with a = pi/2 * k / 2^B, Horner series in Q30
   function automatic logic [15:0] falloff_q15(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] h;
      logic [63:0] pr;
      logic [63:0] term;
      x = (PI_HALF_Q30 * 64'(k)) >> COS_TABLE_BITS;
      x2 = (x * x) >> 30;
      h = Q30_ONE;
      for (int n = 8; n >= 1; n--) begin
         pr = (x2 * h) >> 30;
         case (n)
            8: term = pr / 240;
            7: term = pr / 182;
            6: term = pr / 132;
            5: term = pr / 90;
            4: term = pr / 56;
            3: term = pr / 30;
            2: term = pr / 12;
            default: term = pr / 2;
         endcase
         h = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
      end
      pr = (h * h + (64'd1 << 44)) >> 45;
      return pr[15:0];
   endfunction

   function automatic cos_tab_type cos_tab_build();
      cos_tab_type t;
      for (int k = 0; k < COS_ENTRIES; k++) begin
         t[k] = falloff_q15(k);
      end
      return t;
   endfunction

   localparam cos_tab_type COS_TAB = cos_tab_build();

endpackage
`default_nettype wire

>>> src/bmvw_isqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module bmvw_isqrt
   import bmvw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [RAD_W-1:0]  rad,
   output logic      [ROOT_W-1:0] root
);

   logic [RAD_W:0] v_ff  [ISQ_LAT];
   logic [RAD_W:0] r_ff  [ISQ_LAT];
   logic [RAD_W:0] v_in  [ISQ_LAT];
   logic [RAD_W:0] r_in  [ISQ_LAT];

   always_comb begin
      logic [RAD_W:0] pv;
      logic [RAD_W:0] pr;
      logic [RAD_W:0] bt;
      for (int i = 0; i < ISQ_LAT; i++) begin
         pv = (i == 0) ? (RAD_W+1)'(rad) : v_ff[i-1];
         pr = (i == 0) ? '0 : r_ff[i-1];
         bt = (RAD_W+1)'(1) << (2 * (ISQ_LAT - 1 - i));
         if (pv >= pr + bt) begin
            v_in[i] = pv - (pr + bt);
            r_in[i] = (pr >> 1) + bt;
         end else begin
            v_in[i] = pv;
            r_in[i] = pr >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= v_in;
         r_ff <= r_in;
      end
   end

   assign root = r_ff[ISQ_LAT-1][ROOT_W-1:0];

endmodule
`default_nettype wire

>>> src/bmvw_div.sv
// Pipelined restoring divider by the brush radius, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module bmvw_div
   import bmvw_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [14:0]      divisor,
   input  wire logic [DVD_W-1:0] dividend,
   output logic      [QUO_W-1:0] quotient
);

   logic [DVD_W-1:0] rem_ff [DIV_LAT];
   logic [QUO_W-1:0] q_ff   [DIV_LAT];
   logic [DVD_W-1:0] rem_in [DIV_LAT];
   logic [QUO_W-1:0] q_in   [DIV_LAT];

   always_comb begin
      logic [DVD_W-1:0] pr;
      logic [QUO_W-1:0] pq;
      logic [DVD_W:0]   sd;
      for (int i = 0; i < DIV_LAT; i++) begin
         pr = (i == 0) ? dividend : rem_ff[i-1];
         pq = (i == 0) ? '0 : q_ff[i-1];
         sd = (DVD_W+1)'(divisor) << (DIV_LAT - 1 - i);
         q_in[i] = pq;
         if ((DVD_W+1)'(pr) >= sd) begin
            rem_in[i] = pr - sd[DVD_W-1:0];
            q_in[i][DIV_LAT-1-i] = 1'b1;
         end else begin
            rem_in[i] = pr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign quotient = q_ff[DIV_LAT-1];

endmodule
`default_nettype wire

>>> src/bmvw_apply.sv
// Four-stage displacement of one axis: scale, multiply, round, saturate.
`timescale 1ns / 1ps
`default_nettype none
module bmvw_apply
   import bmvw_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         en,
   input  wire apply_op_type op,
   output logic signed [15:0] result
);

   logic signed [32:0] mp_ff;
   logic signed [16:0] d1_ff;
   logic signed [15:0] v1_ff, v2_ff, v3_ff;
   logic               c1_ff, c2_ff, c3_ff;
   logic signed [49:0] prod_ff;
   logic signed [21:0] sum_ff;
   logic signed [15:0] res_ff;

   logic signed [49:0] rnd_full;
   logic signed [20:0] rnd;
   logic signed [21:0] sum_in;
   logic signed [15:0] res_in;

   always_comb begin
      rnd_full = prod_ff + 50'sd268435456;
      rnd      = $signed(rnd_full[49:29]);
      sum_in   = 22'(v2_ff) + 22'(rnd);
      if (!c3_ff) begin
         res_in = v3_ff;
      end else if (sum_ff > 22'sd32767) begin
         res_in = 16'sh7FFF;
      end else if (sum_ff < -22'sd32768) begin
         res_in = 16'sh8000;
      end else begin
         res_in = sum_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mp_ff   <= 33'(op.p) * $signed({1'b0, op.f});
         d1_ff   <= op.d;
         v1_ff   <= op.v;
         c1_ff   <= op.chg;
         prod_ff <= 50'(mp_ff) * 50'(d1_ff);
         v2_ff   <= v1_ff;
         c2_ff   <= c1_ff;
         sum_ff  <= sum_in;
         v3_ff   <= v2_ff;
         c3_ff   <= c2_ff;
         res_ff  <= res_in;
      end
   end

   assign result = res_ff;

endmodule
`default_nettype wire

>>> src/brush_mesh_vertex_warp_unit.sv
// Top level of the brush mesh vertex warp: stream ports, registers, pipeline, output queue.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Payload                                      Transaction
// req_*     in   tdata {vertex_y, vertex_x}, tlast end_of_mesh tvalid & tready
// rsp_*     out  tdata {warped_y, warped_x}, tuser in_brush,   tvalid & tready
//                tlast end_flag
// csr_*     in   addr register index, wdata value             csr_we
//
// One vertex per cycle while the output queue has room; each vertex passes through the
// pipe and then the output queue. Depth is set by the root unit (one bit per stage) and
// the radius divider (one quotient bit per stage) in series.
// Reset is synchronous and clears valid bits, queue and registers to defaults.
// The whole pipe advances while the two-entry output queue has room; a full
// queue holds every stage in place.
module brush_mesh_vertex_warp_unit
   import bmvw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // slave side
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [15:0] vertex_x, [31:16] vertex_y
   input  wire logic        req_tlast,   // end_of_mesh
   // master side
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // [15:0] warped_x, [31:16] warped_y
   output logic             rsp_tuser,   // [0] in_brush
   output logic             rsp_tlast,   // end_flag
   // configuration
   input  wire logic        csr_we,
   input  wire csr_idx_type csr_addr,
   input  wire logic [15:0] csr_wdata
);

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               in_brush;
      logic               last;
   } out_type;

   // ---------------- configuration registers ----------------
   mode_type           warp_mode_ff;
   logic signed [15:0] center_x_ff, center_y_ff;
   logic [14:0]        brush_radius_ff;
   logic signed [15:0] strength_x_ff, strength_y_ff;
   logic signed [15:0] target_x_ff, target_y_ff;
   logic [29:0]        rr_ff;   // radius squared, follows brush_radius_ff

   always_ff @(posedge clock) begin
      if (reset) begin
         warp_mode_ff    <= MODE_MAGNIFY;
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         brush_radius_ff <= 15'd256;
         strength_x_ff   <= '0;
         strength_y_ff   <= '0;
         target_x_ff     <= '0;
         target_y_ff     <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_WARP_MODE:    warp_mode_ff    <= csr_wdata[2:0];
            CSR_CENTER_X:     center_x_ff     <= csr_wdata;
            CSR_CENTER_Y:     center_y_ff     <= csr_wdata;
            CSR_BRUSH_RADIUS: brush_radius_ff <= csr_wdata[14:0];
            CSR_STRENGTH_X:   strength_x_ff   <= csr_wdata;
            CSR_STRENGTH_Y:   strength_y_ff   <= csr_wdata;
            CSR_TARGET_X:     target_x_ff     <= csr_wdata;
            CSR_TARGET_Y:     target_y_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rr_ff <= 30'(brush_radius_ff) * 30'(brush_radius_ff);
   end

   // ---------------- flow control ----------------
   logic [1:0] cnt_ff;
   logic       adv;
   assign adv        = (cnt_ff != 2'd2);
   assign req_tready = adv;

   // ---------------- side line: vertex, deltas, flags per stage ----------------
   side_type side_ff [1:LAT];
   side_type side_in [1:LAT];

   logic [32:0] sqx_ff, sqy_ff;
   logic [33:0] r2_ff;
   logic        inside_c;

   always_comb begin
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      vx = req_tdata[15:0];
      vy = req_tdata[31:16];
      inside_c = (brush_radius_ff != '0) &&
                 ((34'(sqx_ff) + 34'(sqy_ff)) <= 34'(rr_ff));
      for (int i = 1; i <= LAT; i++) begin
         if (i == 1) begin
            side_in[i].vld      = req_tvalid;
            side_in[i].vx       = vx;
            side_in[i].vy       = vy;
            side_in[i].dx       = 17'(vx) - 17'(center_x_ff);
            side_in[i].dy       = 17'(vy) - 17'(center_y_ff);
            side_in[i].last     = req_tlast;
            side_in[i].in_brush = 1'b0;
         end else begin
            side_in[i] = side_ff[i-1];
            if (i == S_R2) begin
               side_in[i].in_brush = inside_c;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= LAT; i++) begin
            side_ff[i].vld <= 1'b0;
         end
      end else if (adv) begin
         side_ff <= side_in;
      end
   end

   // ---------------- distance: squares, then sum ----------------
   logic signed [33:0] sqx_w, sqy_w;
   assign sqx_w = 34'(side_ff[1].dx) * 34'(side_ff[1].dx);
   assign sqy_w = 34'(side_ff[1].dy) * 34'(side_ff[1].dy);

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff <= sqx_w[32:0];
         sqy_ff <= sqy_w[32:0];
         r2_ff  <= 34'(sqx_ff) + 34'(sqy_ff);
      end
   end

   // ---------------- table index: sqrt(r2)*2^B / R ----------------
   logic [ROOT_W-1:0] root_k;
   logic [QUO_W-1:0]  k_q;
   logic [K_W-1:0]    k_idx;
   logic [15:0]       s_ff;

   bmvw_isqrt u_isqrt_k (
      .clock (clock),
      .en    (adv),
      .rad   (RAD_W'(r2_ff[29:0]) << (2 * COS_TABLE_BITS)),
      .root  (root_k)
   );

   bmvw_div u_div_k (
      .clock    (clock),
      .en       (adv),
      .divisor  (brush_radius_ff),
      .dividend (DVD_W'(root_k)),
      .quotient (k_q)
   );

   assign k_idx = (k_q > QUO_W'(COS_ENTRIES - 1)) ? K_W'(COS_ENTRIES - 1) : k_q[K_W-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff <= COS_TAB[k_idx];
      end
   end

   // ---------------- height-shaped weights ----------------
   // x: (|dx|/R)^4 in Q15; y: (dy/R)^1.5 in Q15 for vertices below the center
   logic [16:0]       adx;
   logic [15:0]       dyp;
   logic [QUO_W-1:0]  tx_q, ty_q;
   logic [15:0]       t2_ff, w4_ff;
   logic [15:0]       w4_dly_ff [W4_DLY];
   logic [15:0]       ty_dly_ff [ISQ_LAT];
   logic [ROOT_W-1:0] rt;
   logic [15:0]       w15_ff, w15a_ff, w15b_ff;

   assign adx = side_ff[1].dx[16] ? 17'(-side_ff[1].dx) : 17'(side_ff[1].dx);
   assign dyp = (side_ff[1].dy > 17'sd0) ? side_ff[1].dy[15:0] : 16'd0;

   bmvw_div u_div_tx (
      .clock    (clock),
      .en       (adv),
      .divisor  (brush_radius_ff),
      .dividend (DVD_W'({adx[15:0], 15'd0})),
      .quotient (tx_q)
   );

   bmvw_div u_div_ty (
      .clock    (clock),
      .en       (adv),
      .divisor  (brush_radius_ff),
      .dividend (DVD_W'({dyp, 15'd0})),
      .quotient (ty_q)
   );

   bmvw_isqrt u_isqrt_ty (
      .clock (clock),
      .en    (adv),
      .rad   (RAD_W'({ty_q[15:0], 15'd0})),
      .root  (rt)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         t2_ff <= mul_q15(tx_q[15:0], tx_q[15:0]);
         w4_ff <= mul_q15(t2_ff, t2_ff);
         for (int i = 0; i < W4_DLY; i++) begin
            w4_dly_ff[i] <= (i == 0) ? w4_ff : w4_dly_ff[i-1];
         end
         for (int i = 0; i < ISQ_LAT; i++) begin
            ty_dly_ff[i] <= (i == 0) ? ty_q[15:0] : ty_dly_ff[i-1];
         end
         w15_ff  <= mul_q15(ty_dly_ff[ISQ_LAT-1], rt[15:0]);
         w15a_ff <= w15_ff;
         w15b_ff <= w15a_ff;
      end
   end

   // ---------------- per-axis operands by mode ----------------
   apply_op_type op_x_in, op_y_in, op_x_ff, op_y_ff;

   always_comb begin
      side_type sd;
      mode_type md;
      sd = side_ff[S_S];
      md = warp_mode_ff;
      op_x_in.v   = sd.vx;
      op_y_in.v   = sd.vy;
      op_x_in.p   = strength_x_ff;
      op_y_in.p   = (md == MODE_ELLIPSE) ? strength_y_ff : strength_x_ff;
      op_x_in.f   = (md == MODE_HEIGHT) ? mul_q15(s_ff, w4_dly_ff[W4_DLY-1]) : s_ff;
      op_y_in.f   = (md == MODE_HEIGHT && sd.dy > 17'sd0) ? mul_q15(s_ff, w15b_ff) : s_ff;
      op_x_in.d   = (md == MODE_FORWARD) ? 17'(target_x_ff) - 17'(center_x_ff) : sd.dx;
      op_y_in.d   = (md == MODE_FORWARD) ? 17'(target_y_ff) - 17'(center_y_ff) : sd.dy;
      op_x_in.chg = sd.in_brush && (md == MODE_FORWARD || md == MODE_MAGNIFY ||
                                    md == MODE_ELLIPSE || md == MODE_HEIGHT);
      op_y_in.chg = sd.in_brush && (md == MODE_FORWARD || md == MODE_MAGNIFY ||
                                    md == MODE_ELLIPSE || md == MODE_HEIGHT ||
                                    md == MODE_VERTICAL);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op_x_ff <= op_x_in;
         op_y_ff <= op_y_in;
      end
   end

   logic signed [15:0] res_x, res_y;

   bmvw_apply u_apply_x (
      .clock  (clock),
      .en     (adv),
      .op     (op_x_ff),
      .result (res_x)
   );

   bmvw_apply u_apply_y (
      .clock  (clock),
      .en     (adv),
      .op     (op_y_ff),
      .result (res_y)
   );

   // ---------------- two-entry output queue ----------------
   out_type buf_ff [2];
   logic    wr_ptr_ff, rd_ptr_ff;
   logic    push, pop;

   assign push = adv && side_ff[LAT].vld;
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= '{x: res_x, y: res_y,
                                in_brush: side_ff[LAT].in_brush, last: side_ff[LAT].last};
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {buf_ff[rd_ptr_ff].y, buf_ff[rd_ptr_ff].x};
   assign rsp_tuser  = buf_ff[rd_ptr_ff].in_brush;
   assign rsp_tlast  = buf_ff[rd_ptr_ff].last;

`ifndef NO_ASSERTIONS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output queue count out of range");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(side_ff[LAT]))
      else $error("last stage changed during stall");

   a_outside_passes: assert property (@(posedge clock) disable iff (reset)
      side_ff[LAT].vld && !side_ff[LAT].in_brush |->
         res_x == side_ff[LAT].vx && res_y == side_ff[LAT].vy)
      else $error("vertex outside brush was moved");
`endif

endmodule
`default_nettype wire

>>> verif/brush_mesh_vertex_warp_checker.sv
// Checker for the brush mesh vertex warp: mirrors registers, predicts results, compares.
`timescale 1ns / 1ps
`default_nettype none
module brush_mesh_vertex_warp_checker
   import bmvw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        rsp_tlast,
   input  wire logic        csr_we,
   input  wire csr_idx_type csr_addr,
   input  wire logic [15:0] csr_wdata,
   output int               fail_count,
   output int               pending
);

   typedef struct packed {
      logic [15:0] wx;
      logic [15:0] wy;
      logic        inb;
      logic        endf;
   } warp_result_type;

   warp_result_type expected_warps[$];

   mode_type    cur_mode;
   logic signed [15:0] cx, cy, sx, sy, tgx, tgy;
   logic [14:0] radius;
   logic [15:0] cos_lut[0:COS_ENTRIES-1];

   assign pending = expected_warps.size();

   function automatic longint unsigned root64(input longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // raised-cosine falloff as cos^2 of half angle, Horner series in Q30
   function automatic logic [15:0] cos_sq(input int k);
      longint unsigned x, x2, h, t;
      x = (64'd1686629713 * 64'(k)) >> COS_TABLE_BITS;
      x2 = (x * x) >> 30;
      h = 64'd1 << 30;
      for (int n = 8; n >= 1; n--) begin
         t = ((x2 * h) >> 30) / 64'((2 * n) * (2 * n - 1));
         h = (t >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
      end
      return 16'((h * h + (64'd1 << 44)) >> 45);
   endfunction

   function automatic logic [31:0] q15_mul(input logic [31:0] a, input logic [31:0] b);
      return 32'((64'(a) * 64'(b) + 64'd16384) >> 15);
   endfunction

   function automatic logic [15:0] sat_q12(input longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return 16'(v);
   endfunction

   // v + round-half-up(p*f*d / 2^29); arithmetic shift is a floor
   function automatic longint nudge(input longint v, input longint p, input longint f,
                                    input longint d);
      longint prod;
      prod = p * f * d + (64'sd1 << 28);
      return v + (prod >>> 29);
   endfunction

   function automatic warp_result_type warp_vertex(input logic [31:0] data, input logic eom);
      warp_result_type r;
      longint vx, vy, dx, dy, nx, ny, px;
      longint unsigned r2, k, tx, t2, w4, ty, rt, w15;
      logic [15:0] s;
      logic inb;
      vx = longint'($signed(data[15:0]));
      vy = longint'($signed(data[31:16]));
      dx = vx - cx;
      dy = vy - cy;
      r2 = dx * dx + dy * dy;
      nx = vx;
      ny = vy;
      px = sx;
      inb = (radius != 0) && (r2 <= 64'(radius) * 64'(radius));
      if (inb) begin
         k = root64(r2 << (2 * COS_TABLE_BITS)) / radius;
         if (k > 64'(COS_ENTRIES - 1)) k = 64'(COS_ENTRIES - 1);
         s = cos_lut[k];
         case (cur_mode)
            MODE_FORWARD: begin
               nx = nudge(vx, px, s, longint'(tgx) - cx);
               ny = nudge(vy, px, s, longint'(tgy) - cy);
            end
            MODE_MAGNIFY: begin
               nx = nudge(vx, px, s, dx);
               ny = nudge(vy, px, s, dy);
            end
            MODE_ELLIPSE: begin
               nx = nudge(vx, px, s, dx);
               ny = nudge(vy, longint'(sy), s, dy);
            end
            MODE_HEIGHT: begin
               tx = (64'(dx < 0 ? -dx : dx) << 15) / radius;
               t2 = q15_mul(tx, tx);
               w4 = q15_mul(t2, t2);
               nx = nudge(vx, px, q15_mul(s, w4), dx);
               if (dy > 0) begin
                  ty = (64'(dy) << 15) / radius;
                  rt = root64(ty << 15);
                  w15 = q15_mul(ty, rt);
                  ny = nudge(vy, px, q15_mul(s, w15), dy);
               end else begin
                  ny = nudge(vy, px, s, dy);
               end
            end
            MODE_VERTICAL: ny = nudge(vy, px, s, dy);
            default: ;
         endcase
      end
      r.wx = sat_q12(nx);
      r.wy = sat_q12(ny);
      r.inb = inb;
      r.endf = eom;
      return r;
   endfunction

   initial begin
      for (int k = 0; k < COS_ENTRIES; k++) cos_lut[k] = cos_sq(k);
   end

   always @(posedge clock) begin
      warp_result_type exp_r, got;
      if (reset) begin
         cur_mode <= MODE_MAGNIFY;
         cx <= '0; cy <= '0; radius <= 15'd256;
         sx <= '0; sy <= '0; tgx <= '0; tgy <= '0;
         expected_warps.delete();
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) expected_warps.push_back(warp_vertex(req_tdata, req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tuser, rsp_tlast};
            if (expected_warps.size() == 0) begin
               if (fail_count < 10) $display("unexpected result transaction %h", got);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_warps.pop_front();
               if (got !== exp_r) begin
                  if (fail_count < 10)
                     $display("mismatch x %h/%h y %h/%h in %b/%b end %b/%b (exp/act)",
                              exp_r.wx, got.wx, exp_r.wy, got.wy, exp_r.inb, got.inb,
                              exp_r.endf, got.endf);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_WARP_MODE:    cur_mode <= csr_wdata[2:0];
               CSR_CENTER_X:     cx <= csr_wdata;
               CSR_CENTER_Y:     cy <= csr_wdata;
               CSR_BRUSH_RADIUS: radius <= csr_wdata[14:0];
               CSR_STRENGTH_X:   sx <= csr_wdata;
               CSR_STRENGTH_Y:   sy <= csr_wdata;
               CSR_TARGET_X:     tgx <= csr_wdata;
               default:          tgy <= csr_wdata;
            endcase
         end
      end
   end

endmodule
`default_nettype wire

>>> verif/brush_mesh_vertex_warp_unit_tb.sv
// Testbench top for the brush mesh vertex warp: stimulus, register phases and verdict.
`timescale 1ns / 1ps
`default_nettype none
module brush_mesh_vertex_warp_unit_tb;
   import bmvw_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [15:0] vertex_x, [31:16] vertex_y
   logic        req_tlast = 1'b0; // end_of_mesh
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [15:0] warped_x, [31:16] warped_y
   logic        rsp_tuser;        // [0] in_brush
   logic        rsp_tlast;        // end_flag
   logic        csr_we = 1'b0;
   csr_idx_type csr_addr = CSR_WARP_MODE;
   logic [15:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int send_idle_pct = 0;   // chance in 100 that the sender skips a cycle
   int recv_stall_pct = 0;  // chance in 100 that the receiver stalls
   int hold_off = 0;        // long receiver stall, counted down below
   longint cycles = 0;
   logic signed [15:0] cur_cx = 0, cur_cy = 0;
   logic [14:0] cur_rad = 15'd256;

   always #10 clock = ~clock;

   brush_mesh_vertex_warp_unit u_top (.*);

   brush_mesh_vertex_warp_checker u_chk (.*);

   // receiver: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog; slowest run is far below this
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 600000) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic cfg_write(input csr_idx_type idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CENTER_X) cur_cx = val;
      if (idx == CSR_CENTER_Y) cur_cy = val;
      if (idx == CSR_BRUSH_RADIUS) cur_rad = val[14:0];
      @(posedge clock);
   endtask

   // one transaction on the input channel, with random idle cycles first;
   // tvalid stays up for the next call or is dropped by drain
   task automatic send_vertex(input logic [15:0] vx, input logic [15:0] vy, input logic eom);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {vy, vx};
      req_tlast <= eom;
      do @(posedge clock); while (!req_tready);
   endtask

   // mostly vertices near the brush so the warp paths get exercised
   task automatic send_random_vertex();
      logic [15:0] vx, vy;
      int span;
      span = int'(cur_rad) + int'(cur_rad) / 4 + 1;
      if ($urandom_range(9) < 8) begin
         vx = 16'(int'(cur_cx) + $urandom_range(2 * span) - span);
         vy = 16'(int'(cur_cy) + $urandom_range(2 * span) - span);
      end else begin
         vx = 16'($urandom);
         vy = 16'($urandom);
      end
      send_vertex(vx, vy, $urandom_range(15) == 0);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LAT + 8) @(posedge clock);
   endtask

   task automatic random_config(input mode_type m);
      cfg_write(CSR_WARP_MODE, 16'(m));
      cfg_write(CSR_CENTER_X, 16'($urandom));
      cfg_write(CSR_CENTER_Y, 16'($urandom));
      case ($urandom_range(3))
         0: cfg_write(CSR_BRUSH_RADIUS, 16'd1);
         1: cfg_write(CSR_BRUSH_RADIUS, 16'h7fff);
         2: cfg_write(CSR_BRUSH_RADIUS, 16'($urandom_range(64, 4096)));
         default: cfg_write(CSR_BRUSH_RADIUS, 16'($urandom_range(1, 32767)));
      endcase
      cfg_write(CSR_STRENGTH_X, 16'($urandom));
      cfg_write(CSR_STRENGTH_Y, 16'($urandom));
      cfg_write(CSR_TARGET_X, 16'($urandom));
      cfg_write(CSR_TARGET_Y, 16'($urandom));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset config (magnify, zero pressure), then extremes
      send_vertex(16'h0000, 16'h0000, 1'b0);   // at the center
      send_vertex(16'h0100, 16'h0000, 1'b0);   // exactly on the rim
      send_vertex(16'h7fff, 16'h8000, 1'b1);   // far outside
      drain();
      cfg_write(CSR_STRENGTH_X, 16'h7fff);
      cfg_write(CSR_STRENGTH_Y, 16'h8000);
      cfg_write(CSR_TARGET_X, 16'h7fff);
      cfg_write(CSR_TARGET_Y, 16'h8000);
      cfg_write(CSR_CENTER_X, 16'h7f00);
      cfg_write(CSR_CENTER_Y, 16'h8100);
      cfg_write(CSR_BRUSH_RADIUS, 16'h7fff);
      for (int m = 0; m < 8; m++) begin
         // every mode incl. the unused codes; saturation near the corners
         cfg_write(CSR_WARP_MODE, 16'(m));
         send_vertex(16'h7fff, 16'h7fff, 1'b0);
         send_vertex(16'h7e00, 16'h8000, 1'b1);
         drain();
      end
      cfg_write(CSR_BRUSH_RADIUS, 16'd1);
      cfg_write(CSR_CENTER_X, 16'h0000);
      cfg_write(CSR_CENTER_Y, 16'h0000);
      send_vertex(16'h0001, 16'h0000, 1'b0);
      send_vertex(16'h0001, 16'h0001, 1'b0);
      drain();
      cfg_write(CSR_BRUSH_RADIUS, 16'h0000);  // zero radius: all outside
      send_vertex(16'h0000, 16'h0000, 1'b1);
      drain();

      // random phases, each with a fresh setting and an idling profile
      for (int ph = 0; ph < 20; ph++) begin
         random_config(mode_type'(ph < 16 ? ph % 5 : $urandom_range(7)));
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         if (ph == 5) hold_off = 300;  // back-pressure fills the pipe
         for (int i = 0; i < 85; i++) send_random_vertex();
         drain();  // sender pauses until every result is back
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> sim.f
src/bmvw_pkg.sv
src/bmvw_isqrt.sv
src/bmvw_div.sv
src/bmvw_apply.sv
src/brush_mesh_vertex_warp_unit.sv
verif/brush_mesh_vertex_warp_checker.sv
verif/brush_mesh_vertex_warp_unit_tb.sv
